/* rtl/sitoa_pkg.sv */
// shared types and constants for the signed integer to decimal text converter
package sitoa_pkg;

    localparam int unsigned VALUE_BITS = 32;
    localparam int unsigned TDATA_W    = ((VALUE_BITS + 7) / 8) * 8;
    localparam int unsigned NUM_DIGITS = (VALUE_BITS * 30103) / 100000 + 1;
    localparam int unsigned BITS_W     = $clog2(VALUE_BITS);
    localparam int unsigned LEFT_W     = $clog2(NUM_DIGITS + 1);

    localparam logic [7:0] CHAR_ZERO  = 8'd48;
    localparam logic [7:0] CHAR_MINUS = 8'd45;
    localparam logic [3:0] DIGIT_MAX  = 4'd9;
    localparam logic [3:0] ADJ_LIMIT  = 4'd5;
    localparam logic [3:0] ADJ_ADD    = 4'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_SKIP,
        ST_SIGN,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic clear;
        logic conv;
        logic shift;
    } t_chain_ctl;

endpackage

/* rtl/sitoa_cell.sv */
// one bcd digit cell: add-3 shift step during conversion, digit shift during output
module sitoa_cell
    import sitoa_pkg::*;
(
    input  logic       i_clk,
    input  t_chain_ctl i_ctl,
    input  logic       i_bit,
    input  logic [3:0] i_digit_lo,
    output logic       o_bit,
    output logic [3:0] o_digit
);

    logic [3:0] r_digit;
    logic [3:0] n_digit;
    logic [3:0] adj;

    always_comb begin
        adj = (r_digit >= ADJ_LIMIT) ? r_digit + ADJ_ADD : r_digit;
        n_digit = r_digit;
        if (i_ctl.clear) begin
            n_digit = '0;
        end else if (i_ctl.conv) begin
            n_digit = {adj[2:0], i_bit};
        end else if (i_ctl.shift) begin
            n_digit = i_digit_lo;
        end
    end

    always_ff @(posedge i_clk) begin
        r_digit <= n_digit;
    end

    assign o_bit   = adj[3];
    assign o_digit = r_digit;

endmodule

/* rtl/sitoa_chain.sv */
// row of bcd digit cells, least significant cell first
module sitoa_chain
    import sitoa_pkg::*;
(
    input  logic       i_clk,
    input  t_chain_ctl i_ctl,
    input  logic       i_bit,
    output logic [3:0] o_top,
    output logic       o_ovf
);

    logic [NUM_DIGITS-1:0] carry;
    logic [3:0]            digit [NUM_DIGITS];

    for (genvar g = 0; g < NUM_DIGITS; g++) begin : g_cell
        logic       bit_in;
        logic [3:0] digit_lo;
        if (g == 0) begin : g_first
            assign bit_in   = i_bit;
            assign digit_lo = '0;
        end else begin : g_rest
            assign bit_in   = carry[g-1];
            assign digit_lo = digit[g-1];
        end
        sitoa_cell u_cell (
            .i_clk      (i_clk),
            .i_ctl      (i_ctl),
            .i_bit      (bit_in),
            .i_digit_lo (digit_lo),
            .o_bit      (carry[g]),
            .o_digit    (digit[g])
        );
    end

    assign o_top = digit[NUM_DIGITS-1];
    assign o_ovf = carry[NUM_DIGITS-1];

endmodule

/* rtl/signed_int_to_decimal_ascii_top.sv */
// signed integer to decimal ascii text converter, top level
//
// usage:
//   input stream s_axis: one beat carries one signed integer in tdata.
//   output stream m_axis: one beat per character, most significant first;
//   a negative value starts with '-', leading zeros are dropped, zero
//   gives a single '0'. tlast marks the final character of each value.
//   timing: one beat is taken, then the magnitude is shifted one bit per
//   cycle through a row of bcd digit cells. leading zero digits are then
//   dropped at one per cycle, and characters leave at one per cycle while
//   the receiver takes them.
//   s_axis_tready is high only between items, while the output register
//   may still hold the final character of the previous item.
//   a stalled receiver holds the output register and the digit row.
//   reset (synchronous, active low) returns to idle and drops any output.
module signed_int_to_decimal_ascii_top
    import sitoa_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [TDATA_W-1:0] s_axis_tdata,   // value
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [7:0]         m_axis_tdata,   // ascii_char
    output logic               m_axis_tlast
);

    t_state                r_state, n_state;
    logic [VALUE_BITS-1:0] r_mag, n_mag;
    logic                  r_neg, n_neg;
    logic [BITS_W-1:0]     r_bits, n_bits;
    logic [LEFT_W-1:0]     r_left, n_left;
    logic                  r_tvalid, n_tvalid;
    logic [7:0]            r_tdata, n_tdata;
    logic                  r_tlast, n_tlast;

    t_chain_ctl            ctl;
    logic [3:0]            top_digit;
    logic                  ovf;
    logic                  in_beat;
    logic                  slot_free;
    logic [VALUE_BITS-1:0] raw;

    assign raw       = s_axis_tdata[VALUE_BITS-1:0];
    assign in_beat   = s_axis_tvalid && s_axis_tready;
    assign slot_free = !r_tvalid || m_axis_tready;

    sitoa_chain u_chain (
        .i_clk (i_clk),
        .i_ctl (ctl),
        .i_bit (r_mag[VALUE_BITS-1]),
        .o_top (top_digit),
        .o_ovf (ovf)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_tvalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_tvalid <= n_tvalid;
        end
        r_mag   <= n_mag;
        r_neg   <= n_neg;
        r_bits  <= n_bits;
        r_left  <= n_left;
        r_tdata <= n_tdata;
        r_tlast <= n_tlast;
    end

    always_comb begin
        n_state   = r_state;
        n_mag     = r_mag;
        n_neg     = r_neg;
        n_bits    = r_bits;
        n_left    = r_left;
        n_tvalid  = r_tvalid && !m_axis_tready;
        n_tdata   = r_tdata;
        n_tlast   = r_tlast;
        ctl       = '0;
        s_axis_tready = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid) begin
                    n_neg     = raw[VALUE_BITS-1];
                    n_mag     = raw[VALUE_BITS-1] ? (~raw + 1'b1) : raw;
                    n_bits    = BITS_W'(VALUE_BITS - 1);
                    ctl.clear = 1'b1;
                    n_state   = ST_CONV;
                end
            end
            ST_CONV: begin
                ctl.conv = 1'b1;
                n_mag    = {r_mag[VALUE_BITS-2:0], 1'b0};
                n_bits   = r_bits - 1'b1;
                if (r_bits == '0) begin
                    n_left  = LEFT_W'(NUM_DIGITS);
                    n_state = ST_SKIP;
                end
            end
            ST_SKIP: begin
                if (top_digit == '0 && r_left > LEFT_W'(1)) begin
                    ctl.shift = 1'b1;
                    n_left    = r_left - 1'b1;
                end else begin
                    n_state = r_neg ? ST_SIGN : ST_EMIT;
                end
            end
            ST_SIGN: begin
                if (slot_free) begin
                    n_tvalid = 1'b1;
                    n_tdata  = CHAR_MINUS;
                    n_tlast  = 1'b0;
                    n_state  = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (slot_free) begin
                    n_tvalid  = 1'b1;
                    n_tdata   = CHAR_ZERO + {4'b0, top_digit};
                    n_tlast   = (r_left == LEFT_W'(1));
                    ctl.shift = 1'b1;
                    n_left    = r_left - 1'b1;
                    if (r_left == LEFT_W'(1)) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign m_axis_tvalid = r_tvalid;
    assign m_axis_tdata  = r_tdata;
    assign m_axis_tlast  = r_tlast;

    a_accept_starts_conv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_beat |=> (r_state == ST_CONV))
        else $error("accepted beat did not start conversion");

    a_no_bcd_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CONV) |-> !ovf)
        else $error("digit row overflowed during conversion");

    a_emit_digit_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT) |-> (top_digit <= DIGIT_MAX))
        else $error("non-decimal digit at output");

    a_minus_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata == CHAR_MINUS) |-> !m_axis_tlast)
        else $error("sign character marked as last");

endmodule

/* tb/sitoa_text_checker.sv */
// checker that predicts the decimal text of each value and compares the output beats
`timescale 1ns / 1ps

module sitoa_text_checker
    import sitoa_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  logic [TDATA_W-1:0] i_in_data,    // value
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  logic [7:0]         i_out_data,   // ascii_char
    input  logic               i_out_last,
    output int                 o_fail_count,
    output int                 o_chars_pending
);

    localparam int unsigned RADIX      = 10;
    localparam int          REPORT_MAX = 10;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } t_text_char;

    t_text_char text_q[$];
    int         fail_count = 0;

    function automatic void queue_decimal_text(input logic [VALUE_BITS-1:0] value);
        logic [VALUE_BITS-1:0] mag;
        logic [3:0]            digits[NUM_DIGITS];
        int                    ndig;
        // magnitude as unsigned, so the most negative value needs no special path
        mag  = value[VALUE_BITS-1] ? -value : value;
        ndig = 0;
        do begin
            digits[ndig] = 4'(mag % RADIX);
            mag          = mag / RADIX;
            ndig++;
        end while (mag != 0);
        if (value[VALUE_BITS-1]) begin
            text_q.push_back('{ch: CHAR_MINUS, last: 1'b0});
        end
        for (int k = ndig - 1; k >= 0; k--) begin
            text_q.push_back('{ch: CHAR_ZERO + 8'(digits[k]), last: (k == 0)});
        end
    endfunction

    always @(posedge i_clk) begin
        t_text_char want;
        if (i_rst_n) begin
            if (i_out_valid && i_out_ready) begin
                if (text_q.size() == 0) begin
                    fail_count++;
                    if (fail_count <= REPORT_MAX) begin
                        $display("%0t: unexpected beat char %0d last %0b",
                                 $realtime, i_out_data, i_out_last);
                    end
                end else begin
                    want = text_q.pop_front();
                    if (want.ch !== i_out_data || want.last !== i_out_last) begin
                        fail_count++;
                        if (fail_count <= REPORT_MAX) begin
                            $display("%0t: mismatch char exp %0d got %0d, last exp %0b got %0b",
                                     $realtime, want.ch, i_out_data, want.last, i_out_last);
                        end
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                queue_decimal_text(i_in_data[VALUE_BITS-1:0]);
            end
        end
        o_fail_count    <= fail_count;
        o_chars_pending <= text_q.size();
    end

endmodule

/* tb/signed_int_to_decimal_ascii_top_tb.sv */
// testbench top: clock, reset, value stimulus, output back-pressure and verdict
`timescale 1ns / 1ps

module signed_int_to_decimal_ascii_top_tb;
    import sitoa_pkg::*;

    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 100;
    localparam int PHASE_ITEMS  = 120;
    localparam int NUM_DIRECTED = 20;

    logic               i_clk         = 1'b0;
    logic               i_rst_n       = 1'b0;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    logic [TDATA_W-1:0] s_axis_tdata  = '0;   // value
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    logic [7:0]         m_axis_tdata;         // ascii_char
    logic               m_axis_tlast;

    int fail_count;
    int chars_pending;
    int src_idle_pct = 24;
    int snk_idle_pct = 77;
    int quiet_cycles = 0;

    logic signed [31:0] directed_values[NUM_DIRECTED] = '{
        0, 1, -1, 5, -5, 9, 10, -10, 99, 100,
        999999999, -999999999, 1000000000, 1234567890, -1234567890,
        2147483647, -2147483647, 32'sh8000_0000, 2147483646, -100
    };

    signed_int_to_decimal_ascii_top uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    sitoa_text_checker text_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (s_axis_tvalid),
        .i_in_ready      (s_axis_tready),
        .i_in_data       (s_axis_tdata),
        .i_out_valid     (m_axis_tvalid),
        .i_out_ready     (m_axis_tready),
        .i_out_data      (m_axis_tdata),
        .i_out_last      (m_axis_tlast),
        .o_fail_count    (fail_count),
        .o_chars_pending (chars_pending)
    );

    always #5 i_clk = ~i_clk;

    always @(negedge i_clk) begin
        m_axis_tready <= ($urandom_range(0, 99) >= snk_idle_pct);
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("status: fail");
                $finish;
            end
        end
    end

    // mostly values of a chosen decimal length, plus raw words and digit boundaries
    function automatic logic [31:0] random_value();
        longint lo;
        longint hi;
        longint mag;
        int     len;
        int     kind;
        kind = $urandom_range(0, 9);
        len  = $urandom_range(1, 10);
        lo   = 1;
        for (int k = 1; k < len; k++) begin
            lo = lo * 10;
        end
        hi = lo * 10 - 1;
        if (hi > 64'sd2147483647) begin
            hi = 64'sd2147483647;
        end
        if (kind < 3) begin
            return $urandom;
        end else if (kind < 8) begin
            if (len == 1) begin
                lo = 0;
            end
            mag = lo + (longint'($urandom) % (hi - lo + 1));
        end else begin
            mag = ($urandom_range(0, 1) != 0) ? hi : lo;
        end
        return 32'(($urandom_range(0, 1) != 0) ? -mag : mag);
    endfunction

    task automatic send_value(input logic [31:0] value);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = value;
        do begin
            @(posedge i_clk);
        end while (!s_axis_tready);
        @(negedge i_clk);
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    src_idle_pct = 24;
                    snk_idle_pct = 77;
                end
                1: begin
                    src_idle_pct = 77;
                    snk_idle_pct = 24;
                end
                default: begin
                    src_idle_pct = 0;
                    snk_idle_pct = 0;
                end
            endcase
            if (phase == 0) begin
                foreach (directed_values[i]) begin
                    send_value(directed_values[i]);
                end
            end
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                send_value(random_value());
            end
        end
        s_axis_tvalid = 1'b0;
        @(posedge i_clk);
        while (chars_pending != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && chars_pending == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
